// ===== rtl/mh64_pkg.sv =====
// ----------------------------------------------------------------------------
// mh64_pkg
// Shared constants and types for the MurmurHash64A engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mh64_pkg;

   localparam logic [63:0] MUL_M   = 64'hc6a4_a793_5bd1_e995;
   localparam int          SHIFT_R = 47;
   localparam logic [31:0] SEED_RESET = 32'h1234_ABCD;
   localparam logic [3:0]  FULL_COUNT = 4'd8;

   // one accepted word after classification, as it travels to the back end
   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  byte_count;   // already clamped to 0..8
      logic        first_word;
      logic        last_word;
      logic [31:0] msg_length;   // already masked to the length width
   } word_entry_type;

endpackage

`default_nettype wire

// ===== rtl/mh64_mul.sv =====
// ----------------------------------------------------------------------------
// mh64_mul
// Two-stage multiply by the MurmurHash constant, modulo 2^64.
// Stage one forms the 32x32 partial products, stage two adds them.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_mul
   import mh64_pkg::*;
(
   input  wire logic        clock,
   input  wire logic [63:0] mul_a,
   output logic      [63:0] mul_p
);

   localparam logic [31:0] M_LO = MUL_M[31:0];
   localparam logic [31:0] M_HI = MUL_M[63:32];

   logic [31:0] a_lo;
   logic [31:0] a_hi;
   logic [63:0] low_in;
   logic [63:0] low_ff;
   logic [31:0] cross_in;
   logic [31:0] cross_ff;

   assign a_lo = mul_a[31:0];
   assign a_hi = mul_a[63:32];

   // only the low 32 bits of the cross terms reach the low 64 bits
   assign low_in   = {32'd0, a_lo} * {32'd0, M_LO};
   assign cross_in = 32'(a_lo * M_HI) + 32'(a_hi * M_LO);

   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      cross_ff <= cross_in;
   end

   assign mul_p = low_ff + {cross_ff, 32'd0};

endmodule

`default_nettype wire

// ===== rtl/mh64_fifo.sv =====
// ----------------------------------------------------------------------------
// mh64_fifo
// Two-entry word queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_fifo
   import mh64_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           wr_en,
   input  wire word_entry_type wr_entry,
   input  wire logic           rd_en,
   output word_entry_type      rd_entry,
   output logic                fifo_empty,
   output logic                fifo_full
);

   word_entry_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_wr;
   logic       do_rd;

   assign fifo_empty = (count_ff == 2'd0);
   assign fifo_full  = (count_ff == 2'd2);
   assign do_wr      = wr_en && !fifo_full;
   assign do_rd      = rd_en && !fifo_empty;
   assign rd_entry   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mh64_front.sv =====
// ----------------------------------------------------------------------------
// mh64_front
// Input side: takes words, tracks whether a message is open, drops words
// outside a message, clamps the count and holds the seed register.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_front
   import mh64_pkg::*;
#(
   parameter int LEN_WIDTH = 32
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0]  req_byte_count,
   input  wire logic        req_first_word,
   input  wire logic        req_last_word,
   input  wire logic [31:0] req_msg_length,
   input  wire logic        fifo_full,
   output logic             fifo_wr,
   output word_entry_type   fifo_entry,
   input  wire logic        csr_valid,
   input  wire logic [31:0] csr_hash_seed,
   output logic             csr_ready,
   output logic      [31:0] seed
);

   localparam logic [31:0] LEN_MASK =
      (LEN_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << LEN_WIDTH) - 64'd1);

   logic        in_msg_ff;
   logic        in_msg_in;
   logic [31:0] seed_ff;
   logic [31:0] seed_in;
   logic        accept;

   assign accept    = req_push && !fifo_full;
   assign fifo_wr   = accept && (req_first_word || in_msg_ff);
   assign csr_ready = 1'b1;
   assign seed      = seed_ff;

   always_comb begin
      fifo_entry.data_word  = req_data_word;
      fifo_entry.byte_count = (req_byte_count > FULL_COUNT) ? FULL_COUNT : req_byte_count;
      fifo_entry.first_word = req_first_word;
      fifo_entry.last_word  = req_last_word;
      fifo_entry.msg_length = req_msg_length & LEN_MASK;
   end

   always_comb begin
      in_msg_in = in_msg_ff;
      if (accept) begin
         in_msg_in = (req_first_word || in_msg_ff) && !req_last_word;
      end
      seed_in = seed_ff;
      if (csr_valid && csr_ready) begin
         seed_in = csr_hash_seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         seed_ff   <= SEED_RESET;
      end else begin
         in_msg_ff <= in_msg_in;
         seed_ff   <= seed_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mh64_back.sv =====
// ----------------------------------------------------------------------------
// mh64_back
// Hash sequencer: seeds, mixes and folds each word through one shared
// multiplier, runs the final avalanche and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_back
   import mh64_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire word_entry_type head,
   input  wire logic           fifo_empty,
   output logic                fifo_rd,
   input  wire logic [31:0]    seed,
   input  wire logic           rsp_pop,
   output logic                rsp_empty,
   output logic      [63:0]    rsp_hash_value
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SEED  = 6'b000010,
      ST_MIX1  = 6'b000100,
      ST_MIX2  = 6'b001000,
      ST_FOLD  = 6'b010000,
      ST_FINAL = 6'b100000
   } state_type;

   state_type   state_ff;
   state_type   state_in;
   logic        ph_ff;
   logic        ph_in;
   logic [63:0] word_ff;
   logic [63:0] word_in;
   logic [3:0]  cnt_ff;
   logic [3:0]  cnt_in;
   logic        last_ff;
   logic        last_in;
   logic [31:0] len_ff;
   logic [31:0] len_in;
   logic [63:0] h_ff;
   logic [63:0] h_in;
   logic [63:0] x_ff;
   logic [63:0] x_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [63:0] hash_ff;
   logic [63:0] hash_in;
   logic [63:0] mul_a;
   logic [63:0] mul_p;

   function automatic logic [63:0] tail_mask(input logic [3:0] cnt);
      logic [63:0] m;
      case (cnt)
         4'd1:    m = 64'h0000_0000_0000_00FF;
         4'd2:    m = 64'h0000_0000_0000_FFFF;
         4'd3:    m = 64'h0000_0000_00FF_FFFF;
         4'd4:    m = 64'h0000_0000_FFFF_FFFF;
         4'd5:    m = 64'h0000_00FF_FFFF_FFFF;
         4'd6:    m = 64'h0000_FFFF_FFFF_FFFF;
         4'd7:    m = 64'h00FF_FFFF_FFFF_FFFF;
         default: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

   // where a word goes once the running hash is ready for it
   function automatic state_type route(input logic [3:0] cnt, input logic last);
      state_type s;
      if (cnt == FULL_COUNT) begin
         s = ST_MIX1;
      end else if (cnt != 4'd0) begin
         s = ST_FOLD;
      end else if (last) begin
         s = ST_FINAL;
      end else begin
         s = ST_IDLE;
      end
      return s;
   endfunction

   mh64_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_p (mul_p)
   );

   assign rsp_empty      = !out_valid_ff;
   assign rsp_hash_value = hash_ff;
   assign fifo_rd        = (state_ff == ST_IDLE) && !fifo_empty;

   always_comb begin
      case (state_ff)
         ST_SEED:  mul_a = {32'd0, len_ff};
         ST_MIX1:  mul_a = word_ff;
         ST_MIX2:  mul_a = x_ff;
         ST_FOLD:  mul_a = h_ff ^ x_ff;
         ST_FINAL: mul_a = h_ff ^ (h_ff >> SHIFT_R);
         default:  mul_a = 64'd0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      h_in         = h_ff;
      x_in         = x_ff;
      hash_in      = hash_ff;
      out_valid_in = out_valid_ff && !rsp_pop;

      case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               word_in = head.data_word;
               cnt_in  = head.byte_count;
               last_in = head.last_word;
               len_in  = head.msg_length;
               x_in    = head.data_word & tail_mask(head.byte_count);
               ph_in   = 1'b0;
               if (head.first_word) begin
                  state_in = ST_SEED;
               end else begin
                  state_in = route(head.byte_count, head.last_word);
               end
            end
         end
         ST_SEED: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               h_in     = {32'd0, seed} ^ mul_p;
               x_in     = word_ff & tail_mask(cnt_ff);
               ph_in    = 1'b0;
               state_in = route(cnt_ff, last_ff);
            end
         end
         ST_MIX1: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               x_in     = mul_p ^ (mul_p >> SHIFT_R);
               ph_in    = 1'b0;
               state_in = ST_MIX2;
            end
         end
         ST_MIX2: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               x_in     = mul_p;
               ph_in    = 1'b0;
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               h_in     = mul_p;
               ph_in    = 1'b0;
               state_in = last_ff ? ST_FINAL : ST_IDLE;
            end
         end
         ST_FINAL: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else if (!out_valid_ff || rsp_pop) begin
               // operand is held, so the product stays put while the slot is busy
               hash_in      = mul_p ^ (mul_p >> SHIFT_R);
               out_valid_in = 1'b1;
               ph_in        = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ph_in    = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         h_ff         <= 64'd0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         out_valid_ff <= out_valid_in;
         h_ff         <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
      len_ff  <= len_in;
      x_ff    <= x_in;
      hash_ff <= hash_in;
   end

endmodule

`default_nettype wire

// ===== rtl/murmur_hash64a_engine_top.sv =====
// ----------------------------------------------------------------------------
// murmur_hash64a_engine_top
// MurmurHash64A over a stream of little-endian 64-bit words.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   req     | req_push/req_full  | data_word, byte_count, first/last, length
//   rsp     | rsp_pop/rsp_empty  | hash_value
//   csr     | csr_valid/ready    | hash_seed (ready always high)
//
// Each multiply goes through one shared 64-bit multiplier; the back end takes
// a word only once done with the last: a full word is mixed and folded, a
// short word folded, a first word seeded first, a last one ends in the avalanche.
// A two-word queue lets the input keep taking words while the back end works.
// Reset is synchronous; the seed returns to 0x1234ABCD, no message is open.
// A finished hash waits in the output register; the back end holds while it
// is full and the next hash is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur_hash64a_engine_top
   import mh64_pkg::*;
#(
   parameter int LEN_WIDTH = 32
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0]  req_byte_count,
   input  wire logic        req_first_word,
   input  wire logic        req_last_word,
   input  wire logic [31:0] req_msg_length,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic      [63:0] rsp_hash_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_hash_seed
);

   word_entry_type wr_entry;
   word_entry_type rd_entry;
   logic           fifo_wr;
   logic           fifo_rd;
   logic           fifo_empty;
   logic           fifo_full;
   logic [31:0]    seed;

   assign req_full = fifo_full;

   mh64_front #(
      .LEN_WIDTH (LEN_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_first_word (req_first_word),
      .req_last_word  (req_last_word),
      .req_msg_length (req_msg_length),
      .fifo_full      (fifo_full),
      .fifo_wr        (fifo_wr),
      .fifo_entry     (wr_entry),
      .csr_valid      (csr_valid),
      .csr_hash_seed  (csr_hash_seed),
      .csr_ready      (csr_ready),
      .seed           (seed)
   );

   mh64_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (fifo_wr),
      .wr_entry   (wr_entry),
      .rd_en      (fifo_rd),
      .rd_entry   (rd_entry),
      .fifo_empty (fifo_empty),
      .fifo_full  (fifo_full)
   );

   mh64_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (rd_entry),
      .fifo_empty     (fifo_empty),
      .fifo_rd        (fifo_rd),
      .seed           (seed),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for murmur_hash64a_engine_top.
// Messages go in as streams of 64-bit words, clean and malformed, under
// random idling on both sides. An in-bench model of the hash predicts every
// result, and each popped hash is compared against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
   import mh64_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_WORDS   = 1250;
   localparam int unsigned LONG_HOLD      = 400;
   localparam int unsigned SETTLE_CYCLES  = 48;
   localparam int unsigned DRAIN_CYCLES   = 64;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned MAX_REPORTS    = 10;

   typedef struct {
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        first_word;
      logic        last_word;
      logic [31:0] msg_length;
   } req_word_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [63:0] req_data_word;
   logic [3:0]  req_byte_count;
   logic        req_first_word;
   logic        req_last_word;
   logic [31:0] req_msg_length;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [63:0] rsp_hash_value;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_hash_seed;

   // model state
   logic [31:0] model_seed;
   logic [63:0] model_hash;
   bit          model_open;
   logic [63:0] hash_q[$];

   bit          req_steady;
   bit          rsp_steady;
   bit          hold_request;

   int unsigned errors;
   int unsigned words_counted;
   int unsigned words_ignored;
   int unsigned msgs_sent;
   int unsigned hashes_checked;
   int unsigned seeds_written;
   int unsigned full_stall_cycles;
   int unsigned quiet_cycles;

   murmur_hash64a_engine_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_first_word (req_first_word),
      .req_last_word  (req_last_word),
      .req_msg_length (req_msg_length),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hash_value (rsp_hash_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_hash_seed  (csr_hash_seed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap(input bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] rand_data();
      int unsigned r;
      r = $urandom_range(15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom(), $urandom()};
   endfunction

   function automatic req_word_type make_word(input logic [63:0] data, input logic [3:0] cnt,
                                              input bit first, input bit last,
                                              input logic [31:0] len);
      req_word_type w;
      w.data_word  = data;
      w.byte_count = cnt;
      w.first_word = first;
      w.last_word  = last;
      w.msg_length = len;
      return w;
   endfunction

   function automatic void note_failure(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("tb: %s: expected %016h, got %016h", what, want, got);
   endfunction

   // Advance the running hash by one accepted word; queue the hash on a last word.
   function automatic void hash_word(input req_word_type w);
      logic [63:0] h;
      logic [63:0] k;
      logic [63:0] keep;
      logic [63:0] fin;
      logic [3:0]  n;
      if (w.first_word) begin
         model_hash = {32'd0, model_seed} ^ ({32'd0, w.msg_length} * MUL_M);
         model_open = 1'b1;
      end else if (!model_open) begin
         words_ignored++;
         return;
      end
      words_counted++;
      n = (w.byte_count > FULL_COUNT) ? FULL_COUNT : w.byte_count;
      h = model_hash;
      if (n == FULL_COUNT) begin
         k = w.data_word * MUL_M;
         k = k ^ (k >> SHIFT_R);
         k = k * MUL_M;
         h = (h ^ k) * MUL_M;
      end else if (n != 0) begin
         keep = ~64'd0 >> (64 - 8 * n);
         h = (h ^ (w.data_word & keep)) * MUL_M;
      end
      model_hash = h;
      if (w.last_word) begin
         fin = h ^ (h >> SHIFT_R);
         fin = fin * MUL_M;
         fin = fin ^ (fin >> SHIFT_R);
         hash_q.push_back(fin);
         model_open = 1'b0;
      end
   endfunction

   // Hold the word until taken; keep push high when the next word follows at once.
   task automatic send_word(input req_word_type w);
      int unsigned gap;
      req_push       <= 1'b1;
      req_data_word  <= w.data_word;
      req_byte_count <= w.byte_count;
      req_first_word <= w.first_word;
      req_last_word  <= w.last_word;
      req_msg_length <= w.msg_length;
      do @(posedge clock); while (req_full);
      hash_word(w);
      gap = pick_gap(req_steady);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic release_input();
      req_push <= 1'b0;
   endtask

   task automatic send_message(input int unsigned nbytes, input logic [31:0] len,
                               input bit wild);
      int unsigned  left;
      bit           is_first;
      req_word_type w;
      left     = nbytes;
      is_first = 1'b1;
      do begin
         w.data_word  = rand_data();
         w.byte_count = (left >= 8) ? FULL_COUNT : 4'(left);
         if (wild && w.byte_count == FULL_COUNT && $urandom_range(7) == 0)
            w.byte_count = 4'($urandom_range(9, 15));
         w.first_word = is_first;
         w.last_word  = (left <= 8);
         w.msg_length = len;
         send_word(w);
         left     = (left >= 8) ? left - 8 : 0;
         is_first = 1'b0;
      end while (!w.last_word);
      msgs_sent++;
   endtask

   // Drain results and let the back end finish silent words before touching the seed.
   task automatic write_seed(input logic [31:0] value);
      release_input();
      while (hash_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_hash_seed <= value;
      do @(posedge clock); while (!csr_ready);
      model_seed = value;
      seeds_written++;
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_cases();
      int unsigned n;
      // empty message under the reset seed
      send_word(make_word(rand_data(), 4'd0, 1'b1, 1'b1, 32'd0));
      for (n = 1; n < 8; n++)
         send_word(make_word('1, 4'(n), 1'b1, 1'b1, n));
      send_word(make_word('0, FULL_COUNT, 1'b1, 1'b1, 32'd8));
      send_word(make_word('1, FULL_COUNT, 1'b1, 1'b1, 32'd8));
      // counts above eight act as full words
      send_word(make_word(64'h0123_4567_89ab_cdef, 4'd15, 1'b1, 1'b0, 32'd16));
      send_word(make_word(64'hfedc_ba98_7654_3210, 4'd9, 1'b0, 1'b1, 32'd16));
      // stray word while idle: dropped
      send_word(make_word(rand_data(), FULL_COUNT, 1'b0, 1'b1, 32'd8));
      // short word in the middle of a message
      send_word(make_word(rand_data(), 4'd3, 1'b1, 1'b0, 32'd11));
      send_word(make_word(rand_data(), FULL_COUNT, 1'b0, 1'b1, 32'd11));
      // new first word abandons the open message
      send_word(make_word(rand_data(), FULL_COUNT, 1'b1, 1'b0, 32'd13));
      send_word(make_word(rand_data(), 4'd5, 1'b1, 1'b1, 32'd5));
      // length field disagrees with the words sent
      send_word(make_word(rand_data(), FULL_COUNT, 1'b1, 1'b0, 32'hffff_ffff));
      send_word(make_word(rand_data(), FULL_COUNT, 1'b0, 1'b1, 32'hffff_ffff));
      // exact multiple of eight ends on an empty last word
      send_word(make_word(rand_data(), FULL_COUNT, 1'b1, 1'b0, 32'd8));
      send_word(make_word(rand_data(), 4'd0, 1'b0, 1'b1, 32'd8));
      msgs_sent += 15;
   endtask

   task automatic test_seed_settings();
      write_seed(32'd0);
      repeat (4) send_message($urandom_range(0, 24), $urandom(), 1'b0);
      write_seed(32'hffff_ffff);
      repeat (4) send_message($urandom_range(0, 24), $urandom(), 1'b0);
      write_seed($urandom());
      repeat (4) send_message($urandom_range(0, 24), $urandom_range(0, 24), 1'b0);
      // seed change while a message is open only hits the next first word
      send_word(make_word(rand_data(), FULL_COUNT, 1'b1, 1'b0, 32'd12));
      write_seed($urandom());
      send_word(make_word(rand_data(), 4'd4, 1'b0, 1'b1, 32'd12));
      send_message(12, 32'd12, 1'b0);
      msgs_sent++;
   endtask

   task automatic test_input_backpressure();
      req_steady   = 1'b1;
      hold_request = 1'b1;
      repeat (16) send_message($urandom_range(0, 20), $urandom_range(0, 20), 1'b0);
      req_steady = 1'b0;
   endtask

   task automatic test_random_traffic();
      int unsigned target;
      int unsigned r;
      int unsigned nbytes;
      int unsigned k;
      int unsigned msg_index;
      target    = words_counted + RANDOM_WORDS;
      msg_index = 0;
      while (words_counted < target) begin
         msg_index++;
         if (msg_index % 60 == 0) begin
            req_steady = ($urandom_range(3) == 0);
            rsp_steady = ($urandom_range(3) == 0);
         end
         if (msg_index % 150 == 0)
            write_seed(($urandom_range(3) == 0) ? 32'hffff_ffff : $urandom());
         r      = $urandom_range(99);
         nbytes = ($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(0, 40);
         if (r < 80) begin
            send_message(nbytes, nbytes, 1'b0);
         end else if (r < 86) begin
            send_message(nbytes, $urandom(), 1'b1);
         end else if (r < 90) begin
            send_word(make_word(rand_data(), 4'($urandom_range(15)), 1'b0,
                                1'($urandom_range(1)), $urandom()));
         end else if (r < 95) begin
            // open a message and leave it hanging
            send_word(make_word(rand_data(), FULL_COUNT, 1'b1, 1'b0, $urandom_range(8, 40)));
            for (k = $urandom_range(0, 2); k != 0; k--)
               send_word(make_word(rand_data(), FULL_COUNT, 1'b0, 1'b0, $urandom()));
         end else begin
            send_word(make_word(rand_data(), FULL_COUNT, 1'b1, 1'b0, 32'd20));
            send_word(make_word(rand_data(), 4'($urandom_range(1, 7)), 1'b0, 1'b0, 32'd20));
            send_word(make_word(rand_data(), 4'($urandom_range(0, 8)), 1'b0, 1'b1, 32'd20));
            msgs_sent++;
         end
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   initial begin : result_side
      logic [63:0] want;
      int unsigned pop_wait;
      pop_wait = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (hash_q.size() == 0) begin
               note_failure("hash with none pending", '0, rsp_hash_value);
            end else begin
               want = hash_q.pop_front();
               hashes_checked++;
               if (rsp_hash_value !== want)
                  note_failure("hash_value mismatch", want, rsp_hash_value);
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            pop_wait     = LONG_HOLD;
            rsp_pop <= 1'b0;
         end else if (pop_wait != 0) begin
            pop_wait--;
            rsp_pop <= 1'b0;
         end else begin
            pop_wait = pick_gap(rsp_steady);
            rsp_pop <= (pop_wait == 0) && !reset;
         end
      end
   end

   initial begin : watchdog
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (req_push && req_full)
            full_stall_cycles++;
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb: watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("tb: failure");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_push       = 1'b0;
      req_data_word  = '0;
      req_byte_count = '0;
      req_first_word = 1'b0;
      req_last_word  = 1'b0;
      req_msg_length = '0;
      rsp_pop        = 1'b0;
      csr_valid      = 1'b0;
      csr_hash_seed  = '0;
      model_seed     = SEED_RESET;
      model_hash     = '0;
      model_open     = 1'b0;
      req_steady     = 1'b0;
      rsp_steady     = 1'b0;
      hold_request   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_seed_settings();
      test_input_backpressure();
      test_random_traffic();

      release_input();
      while (hash_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d messages, %0d hashed words, %0d stray words dropped, %0d hashes checked",
               msgs_sent, words_counted, words_ignored, hashes_checked);
      $display("tb: %0d seed writes, input stalled on full for %0d cycles, %0d errors",
               seeds_written, full_stall_cycles, errors);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
